FILE: src/ptw_pkg.sv
// Package for the page table walker: word types, level codes and result kinds.
`timescale 1ns / 1ps

package ptw_pkg;

    // Operation carried by an input word
    localparam logic OP_TRANSLATE = 1'b0;
    localparam logic OP_RESPONSE  = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_FAULT = 2'd2;

    // Entry bits
    localparam int PRESENT_BIT   = 0;
    localparam int PAGE_SIZE_BIT = 7;

    localparam int ADDR_W = 63;

    // Walk level: which table entry the walk is waiting for
    typedef enum logic [1:0] {
        LEVEL_IDLE = 2'd0,
        LEVEL_PT   = 2'd1,
        LEVEL_DIR  = 2'd2,
        LEVEL_PDPT = 2'd3
    } level_t;

    typedef struct packed {
        logic        op;
        logic [31:0] lin_addr;
        logic [31:0] table_root;
        logic        pae_mode;
        logic [63:0] read_data;
    } ptw_in_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] address;
        logic              wide_read;
    } ptw_out_t;

endpackage

FILE: src/ptw_chan_if.sv
// Valid/ready channel interface carrying one payload word.
`timescale 1ns / 1ps

interface ptw_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: src/x86_page_table_walker.sv
// Top level of the x86 32-bit / PAE page table walker.
`timescale 1ns / 1ps

// The walker takes one input word per cycle while its skid stage is empty:
// a translate request (op 0) or a table entry read response (op 1). Each
// accepted word is decoded against the walk state combinationally, by masking
// and bit selection, and gives at most one result word (entry read request,
// translation done, or not-present fault), registered into the result
// register, or into the one-word skid stage when the result register is held;
// input keeps flowing while a result waits, and input ready drops only when
// both are full. Requests while a walk is in progress and responses while
// idle are dropped without a result.

module x86_page_table_walker (
    input  logic       clk,
    input  logic       rst_n,
    ptw_chan_if.sink   in_ch,
    ptw_chan_if.source out_ch
);

    ptw_pkg::level_t   level_reg, level_next;
    logic [31:0]       lin_reg, lin_next;
    logic              pae_reg, pae_next;

    ptw_pkg::ptw_out_t res_word;
    logic              res_valid;

    logic              out_valid_reg, skid_valid_reg;
    ptw_pkg::ptw_out_t out_word_reg, skid_word_reg;

    logic              in_ready_int;
    logic              in_fire;
    logic              out_free;
    logic [63:0]       ent;
    logic [31:0]       lin;

    assign in_ready_int = !skid_valid_reg;
    assign in_ch.ready  = in_ready_int;
    assign in_fire      = in_ch.valid && in_ready_int;
    assign out_free     = !out_valid_reg || out_ch.ready;

    assign ent = in_ch.data.read_data;
    assign lin = lin_reg;

    // Walk step: next state and result for the incoming word
    always_comb
    begin
        level_next         = level_reg;
        lin_next           = lin_reg;
        pae_next           = pae_reg;
        res_valid          = 1'b0;
        res_word.kind      = ptw_pkg::KIND_READ;
        res_word.address   = '0;
        res_word.wide_read = 1'b0;

        if (in_fire)
        begin
            if (in_ch.data.op == ptw_pkg::OP_TRANSLATE)
            begin
                if (level_reg == ptw_pkg::LEVEL_IDLE)
                begin
                    lin_next  = in_ch.data.lin_addr;
                    pae_next  = in_ch.data.pae_mode;
                    res_valid = 1'b1;
                    if (in_ch.data.pae_mode)
                    begin
                        level_next         = ptw_pkg::LEVEL_PDPT;
                        res_word.address   = {31'b0, in_ch.data.table_root[31:5],
                                              in_ch.data.lin_addr[31:30], 3'b0};
                        res_word.wide_read = 1'b1;
                    end
                    else
                    begin
                        level_next       = ptw_pkg::LEVEL_DIR;
                        res_word.address = {31'b0, in_ch.data.table_root[31:12],
                                            in_ch.data.lin_addr[31:22], 2'b0};
                    end
                end
            end
            else if (level_reg != ptw_pkg::LEVEL_IDLE)
            begin
                res_valid = 1'b1;
                if (!ent[ptw_pkg::PRESENT_BIT])
                begin
                    // not present: end walk with a fault
                    level_next    = ptw_pkg::LEVEL_IDLE;
                    res_word.kind = ptw_pkg::KIND_FAULT;
                end
                else if (pae_reg)
                begin
                    case (level_reg)
                        ptw_pkg::LEVEL_PDPT:
                        begin
                            level_next         = ptw_pkg::LEVEL_DIR;
                            res_word.address   = {ent[62:12], lin[29:21], 3'b0};
                            res_word.wide_read = 1'b1;
                        end
                        ptw_pkg::LEVEL_DIR:
                        begin
                            if (ent[ptw_pkg::PAGE_SIZE_BIT])
                            begin
                                // 2 MB page
                                level_next       = ptw_pkg::LEVEL_IDLE;
                                res_word.kind    = ptw_pkg::KIND_DONE;
                                res_word.address = {ent[62:21], lin[20:0]};
                            end
                            else
                            begin
                                level_next         = ptw_pkg::LEVEL_PT;
                                res_word.address   = {ent[62:12], lin[20:12], 3'b0};
                                res_word.wide_read = 1'b1;
                            end
                        end
                        default:
                        begin
                            level_next       = ptw_pkg::LEVEL_IDLE;
                            res_word.kind    = ptw_pkg::KIND_DONE;
                            res_word.address = {ent[62:12], lin[11:0]};
                        end
                    endcase
                end
                else
                begin
                    if (level_reg == ptw_pkg::LEVEL_PT)
                    begin
                        level_next       = ptw_pkg::LEVEL_IDLE;
                        res_word.kind    = ptw_pkg::KIND_DONE;
                        res_word.address = {31'b0, ent[31:12], lin[11:0]};
                    end
                    else if (ent[ptw_pkg::PAGE_SIZE_BIT])
                    begin
                        // 4 MB page, PSE-36 bits 21:13 give physical 40:32
                        level_next       = ptw_pkg::LEVEL_IDLE;
                        res_word.kind    = ptw_pkg::KIND_DONE;
                        res_word.address = {22'b0, ent[21:13], ent[31:22], lin[21:0]};
                    end
                    else
                    begin
                        level_next       = ptw_pkg::LEVEL_PT;
                        res_word.address = {31'b0, ent[31:12], lin[21:12], 2'b0};
                    end
                end
            end
        end
    end

    // Walk state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= ptw_pkg::LEVEL_IDLE;
            lin_reg   <= '0;
            pae_reg   <= 1'b0;
        end
        else
        begin
            level_reg <= level_next;
            lin_reg   <= lin_next;
            pae_reg   <= pae_next;
        end
    end

    // Output register and skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_free)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= res_valid;
                end
            end
            else if (res_valid)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_word_reg <= skid_word_reg;
            end
            else if (res_valid)
            begin
                out_word_reg <= res_word;
            end
        end
        else if (res_valid)
        begin
            skid_word_reg <= res_word;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_word_reg;

endmodule

FILE: tb/tb_x86_page_table_walker.sv
// Testbench for the x86 32-bit / PAE page table walker: table walks with a local walk model.
`timescale 1ns / 1ps

module tb_x86_page_table_walker;

    import ptw_pkg::*;

    localparam int  WALK_WORDS   = 1450;
    localparam int  LIMIT_CYCLES = 200000;
    localparam int  DRAIN_CYCLES = 16;
    localparam int  QUIET_FROM   = 600;
    localparam int  QUIET_TO     = 1000;
    localparam int  MAX_REPORTS  = 10;

    logic clk;
    logic rst_n;

    ptw_chan_if #(.payload_t(ptw_in_t))  in_ch ();
    ptw_chan_if #(.payload_t(ptw_out_t)) out_ch ();

    x86_page_table_walker i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    // Words waiting to be sent, and the results they are expected to cause
    ptw_in_t  walk_words[$];
    ptw_out_t expected_results[$];

    // Walk model state
    level_t      walk_lvl;
    logic [31:0] lin_saved;
    logic        pae_saved;

    int cycle_count   = 0;
    int error_count   = 0;
    int words_taken   = 0;
    int walks_started = 0;
    int words_dropped = 0;
    int results_seen  = 0;
    int reads_seen    = 0;
    int dones_seen    = 0;
    int faults_seen   = 0;
    int large_pages   = 0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Random stall, switched off for one long quiet stretch
    function automatic bit stall_now();
        if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO)
            return 1'b0;
        return $urandom_range(99) < 10;
    endfunction

    // Next walk step for one accepted word; returns 1 when a result follows
    function automatic bit walk_step(input ptw_in_t w, output ptw_out_t r);
        logic [63:0] lin;
        logic [63:0] ent;
        logic [63:0] addr;
        r = '0;
        addr = '0;
        if (w.op == OP_TRANSLATE)
        begin
            if (walk_lvl != LEVEL_IDLE)
            begin
                words_dropped++;
                return 1'b0;
            end
            walks_started++;
            lin_saved = w.lin_addr;
            pae_saved = w.pae_mode;
            lin = {32'b0, w.lin_addr};
            r.kind = KIND_READ;
            if (pae_saved)
            begin
                walk_lvl = LEVEL_PDPT;
                addr = {32'b0, w.table_root & 32'hffffffe0} | ((lin & 64'hc0000000) >> 27);
                r.wide_read = 1'b1;
            end
            else
            begin
                walk_lvl = LEVEL_DIR;
                addr = {32'b0, w.table_root & 32'hfffff000} | ((lin & 64'hffc00000) >> 20);
            end
            r.address = addr[ADDR_W-1:0];
            return 1'b1;
        end

        if (walk_lvl == LEVEL_IDLE)
        begin
            words_dropped++;
            return 1'b0;
        end

        lin = {32'b0, lin_saved};
        ent = w.read_data;
        if (!pae_saved)
            ent[63:32] = '0;

        // Not present ends the walk at any level
        if (!ent[PRESENT_BIT])
        begin
            walk_lvl = LEVEL_IDLE;
            r.kind = KIND_FAULT;
            return 1'b1;
        end

        if (pae_saved)
        begin
            case (walk_lvl)
                LEVEL_PDPT:
                begin
                    walk_lvl = LEVEL_DIR;
                    r.kind = KIND_READ;
                    r.wide_read = 1'b1;
                    addr = (ent & 64'hfffffffffffff000) | ((lin & 64'h3fe00000) >> 18);
                end
                LEVEL_DIR:
                begin
                    if (ent[PAGE_SIZE_BIT])
                    begin
                        // 2 MB page
                        walk_lvl = LEVEL_IDLE;
                        r.kind = KIND_DONE;
                        large_pages++;
                        addr = (ent & 64'h7fffffffffe00000) | (lin & 64'h001fffff);
                    end
                    else
                    begin
                        walk_lvl = LEVEL_PT;
                        r.kind = KIND_READ;
                        r.wide_read = 1'b1;
                        addr = (ent & 64'h7ffffffffffff000) | ((lin & 64'h001ff000) >> 9);
                    end
                end
                default:
                begin
                    walk_lvl = LEVEL_IDLE;
                    r.kind = KIND_DONE;
                    addr = (ent & 64'h7ffffffffffff000) | (lin & 64'h00000fff);
                end
            endcase
        end
        else if (walk_lvl == LEVEL_DIR || walk_lvl == LEVEL_PDPT)
        begin
            if (ent[PAGE_SIZE_BIT])
            begin
                // 4 MB page, directory bits 21:13 land on physical bits 40:32
                walk_lvl = LEVEL_IDLE;
                r.kind = KIND_DONE;
                large_pages++;
                addr = ((ent & 64'h003fe000) << 19) | (ent & 64'hffc00000) |
                       (lin & 64'h003fffff);
            end
            else
            begin
                walk_lvl = LEVEL_PT;
                r.kind = KIND_READ;
                addr = (ent & 64'hfffff000) | ((lin & 64'h003ff000) >> 10);
            end
        end
        else
        begin
            walk_lvl = LEVEL_IDLE;
            r.kind = KIND_DONE;
            addr = (ent & 64'hfffff000) | (lin & 64'h00000fff);
        end
        r.address = addr[ADDR_W-1:0];
        return 1'b1;
    endfunction

    // Word builders; fields the operation does not use get random values
    function automatic ptw_in_t make_req(logic [31:0] lin, logic [31:0] root, logic pae);
        ptw_in_t w;
        w.op         = OP_TRANSLATE;
        w.lin_addr   = lin;
        w.table_root = root;
        w.pae_mode   = pae;
        w.read_data  = {$urandom, $urandom};
        return w;
    endfunction

    function automatic ptw_in_t make_resp(logic [63:0] ent);
        ptw_in_t w;
        w.op         = OP_RESPONSE;
        w.lin_addr   = $urandom;
        w.table_root = $urandom;
        w.pae_mode   = 1'($urandom_range(1));
        w.read_data  = ent;
        return w;
    endfunction

    // One well-formed walk with random content, now and then disturbed
    task automatic add_walk();
        logic        pae;
        logic        present;
        logic        psize;
        logic [63:0] ent;
        int          lvl;
        pae = 1'($urandom_range(1));
        walk_words.push_back(make_req($urandom, $urandom, pae));
        for (lvl = pae ? 3 : 2; lvl >= 1; lvl--)
        begin
            present = $urandom_range(99) >= 5;
            psize   = $urandom_range(2) == 0;
            ent = {$urandom, $urandom};
            ent[PRESENT_BIT]   = present;
            ent[PAGE_SIZE_BIT] = psize;
            // stray request in the middle of a walk
            if ($urandom_range(99) < 4)
                walk_words.push_back(make_req($urandom, $urandom, 1'($urandom_range(1))));
            walk_words.push_back(make_resp(ent));
            if (!present || (lvl == 2 && psize))
                break;
        end
    endtask

    // Directed walks: field extremes, every level and outcome, dropped words
    task automatic add_directed();
        // response while idle
        walk_words.push_back(make_resp(64'hffffffffffffffff));
        // 32-bit 4 KB walk, all ones; high entry halves must be ignored
        walk_words.push_back(make_req(32'hffffffff, 32'hffffffff, 1'b0));
        walk_words.push_back(make_resp(64'hffffffffffffff7f));
        walk_words.push_back(make_resp(64'hffffffffffffffff));
        // 32-bit 4 MB page with PSE-36 bits
        walk_words.push_back(make_req(32'h00000000, 32'h00000000, 1'b0));
        walk_words.push_back(make_resp(64'h00000000ffffffff));
        // 32-bit fault at directory, high half set
        walk_words.push_back(make_req(32'h12345678, 32'h9abcdef0, 1'b0));
        walk_words.push_back(make_resp(64'hfffffffffffffffe));
        // PAE 4 KB walk, all ones; pointer entry page-size bit not examined
        walk_words.push_back(make_req(32'hffffffff, 32'hffffffff, 1'b1));
        walk_words.push_back(make_resp(64'hffffffffffffffff));
        walk_words.push_back(make_resp(64'hffffffffffffff7f));
        walk_words.push_back(make_resp(64'hffffffffffffffff));
        // PAE 2 MB page
        walk_words.push_back(make_req(32'h00000000, 32'h00000000, 1'b1));
        walk_words.push_back(make_resp(64'h0000000000000001));
        walk_words.push_back(make_resp(64'hffffffffffffffff));
        // PAE fault at page table level
        walk_words.push_back(make_req(32'h5a5a5a5a, 32'ha5a5a5a5, 1'b1));
        walk_words.push_back(make_resp(64'h0000000000000001));
        walk_words.push_back(make_resp(64'h0000000000000001));
        walk_words.push_back(make_resp(64'hfffffffffffffffe));
        // PAE fault at pointer table
        walk_words.push_back(make_req(32'hc0000000, 32'h0000001f, 1'b1));
        walk_words.push_back(make_resp(64'h0000000000000000));
        // request while busy is dropped
        walk_words.push_back(make_req(32'h00400000, 32'h00001000, 1'b0));
        walk_words.push_back(make_req(32'hffffffff, 32'hffffffff, 1'b1));
        walk_words.push_back(make_resp(64'h0000000000000001));
        walk_words.push_back(make_resp(64'h0000000000000001));
    endtask

    // Report one bad result word
    task automatic flag_result(string what, ptw_out_t want, ptw_out_t got);
        if (error_count < MAX_REPORTS)
            $display("%0t: %s: expected kind %0d addr %h wide %0d, got kind %0d addr %h wide %0d",
                     $time, what, want.kind, want.address, want.wide_read,
                     got.kind, got.address, got.wide_read);
        error_count++;
    endtask

    // Driver: present pending words, predict each accepted one
    always @(posedge clk or negedge rst_n)
    begin : drive_words
        ptw_out_t res;
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.data  <= '0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                words_taken++;
                if (walk_step(in_ch.data, res))
                    expected_results.push_back(res);
                void'(walk_words.pop_front());
            end
            if (in_ch.valid && !in_ch.ready)
                ; // hold the word until taken
            else if (walk_words.size() != 0 && !stall_now())
            begin
                in_ch.valid <= 1'b1;
                in_ch.data  <= walk_words[0];
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // Monitor: check each result word against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin : check_results
        ptw_out_t want;
        ptw_out_t got;
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got = out_ch.data;
                results_seen++;
                case (got.kind)
                    KIND_READ:  reads_seen++;
                    KIND_DONE:  dones_seen++;
                    KIND_FAULT: faults_seen++;
                    default:    ;
                endcase
                if (expected_results.size() == 0)
                    flag_result("unexpected result", '0, got);
                else
                begin
                    want = expected_results.pop_front();
                    if (got.kind != want.kind || got.address != want.address ||
                        got.wide_read != want.wide_read)
                        flag_result("result mismatch", want, got);
                end
            end
            out_ch.ready <= !stall_now();
        end
    end

    // Timeout
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_x86_page_table_walker: errors");
            $finish;
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        rst_n        = 1'b0;
        walk_lvl     = LEVEL_IDLE;
        lin_saved    = '0;
        pae_saved    = 1'b0;

        add_directed();
        while (walk_words.size() < WALK_WORDS)
        begin
            if ($urandom_range(99) < 3)
            begin
                // loose word with every field random
                if ($urandom_range(1))
                    walk_words.push_back(make_resp({$urandom, $urandom}));
                else
                    walk_words.push_back(make_req($urandom, $urandom,
                                                  1'($urandom_range(1))));
            end
            else
                add_walk();
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (walk_words.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d words in, %0d walks started, %0d words dropped by a busy or idle walker",
                 words_taken, walks_started, words_dropped);
        $display("%0d results: %0d entry reads, %0d translations (%0d large pages), %0d faults",
                 results_seen, reads_seen, dones_seen, large_pages, faults_seen);
        if (error_count == 0)
            $display("tb_x86_page_table_walker: clean");
        else
            $display("tb_x86_page_table_walker: errors");
        $finish;
    end

endmodule
